>>> src/epwbc_pkg.sv
// shared types and constants for the eeprom page write-back cache
`default_nettype none

package epwbc_pkg;

  // request opcodes
  localparam logic [2:0] OP_WRITE = 3'd0;
  localparam logic [2:0] OP_READ  = 3'd1;
  localparam logic [2:0] OP_FLUSH = 3'd2;
  localparam logic [2:0] OP_FILL  = 3'd3;
  localparam logic [2:0] OP_FAIL  = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_READ     = 2'd0;
  localparam logic [1:0] KIND_DIRTY    = 2'd1;
  localparam logic [1:0] KIND_FILL_REQ = 2'd2;
  localparam logic [1:0] KIND_ERROR    = 2'd3;

  localparam int unsigned ADDR_W = 19;
  localparam int unsigned DEV_W  = 7;
  localparam logic [DEV_W-1:0] DEVICE_BASE_RESET = 7'd80;

  typedef struct packed {
    logic [2:0]        op;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } req_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [DEV_W-1:0] device_address;
    logic [15:0]      word_address;
    logic [7:0]       data_res;
    logic             run_start;
    logic             last;
  } res_t;

endpackage

`default_nettype wire

>>> src/eeprom_page_write_back_cache.sv
// Single-page write-back cache for a serial EEPROM. One page of PAGE_BYTES bytes
// (a power of two, 8 to 32) is held with a dirty flag per byte. A request is taken
// only while the sequencer is idle. Each request passes through accept, decode and
// act; a read hit or the final fill byte adds a page memory read and the result. A
// flush scans the byte positions in order, emits each dirty byte and ends once the
// flags are all clear, since the page memory delivers one byte per read. The act,
// flush emit and result steps wait while res_stall holds back a result.
`default_nettype none

module eeprom_page_write_back_cache
  import epwbc_pkg::*;
#(
  parameter int unsigned PAGE_BYTES = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire req_t        req,
  output logic             res_valid,
  input  wire logic        res_stall,
  output res_t             res,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned OFF_W = $clog2(PAGE_BYTES);
  localparam int unsigned TAG_W = ADDR_W - OFF_W;
  localparam logic [OFF_W-1:0] LAST_OFF = OFF_W'(PAGE_BYTES - 1);

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_DECODE   = 7'b0000010,
    ST_FLUSH    = 7'b0000100,
    ST_FL_OUT   = 7'b0001000,
    ST_ACT      = 7'b0010000,
    ST_RD_ISSUE = 7'b0100000,
    ST_RD_OUT   = 7'b1000000
  } state_t;

  state_t                  state;
  req_t                    r_req;
  logic [DEV_W-1:0]        device_base;
  logic [7:0]              page_mem [PAGE_BYTES];
  logic [7:0]              rdata;
  logic [PAGE_BYTES-1:0]   dirty;
  logic [PAGE_BYTES-1:0]   dirty_rest;
  logic [TAG_W-1:0]        page_tag;
  logic                    page_valid;
  logic                    page_modified;
  logic                    fill_pending;
  logic [OFF_W-1:0]        fill_pos;
  logic [OFF_W-1:0]        req_offset;
  logic [OFF_W-1:0]        idx;
  logic                    prev;
  logic                    retag;
  logic [OFF_W-1:0]        rd_ptr;
  logic [OFF_W-1:0]        rd_addr;
  logic                    mem_we;
  logic [OFF_W-1:0]        mem_wa;
  logic [7:0]              mem_wd;
  logic                    out_free;
  logic                    res_load;
  res_t                    res_next;
  logic [TAG_W-1:0]        in_tag;
  logic [OFF_W-1:0]        in_off;
  logic                    tag_hit;
  logic                    need_flush;
  logic                    valid_eff;
  logic                    cfg_we;

  function automatic res_t make_res(input logic [1:0] kind, input logic [ADDR_W-1:0] baddr,
                                    input logic [7:0] d, input logic run, input logic lst,
                                    input logic [DEV_W-1:0] base);
    res_t r;
    r.kind           = kind;
    r.device_address = base + DEV_W'(baddr[ADDR_W-1:16]);
    r.word_address   = baddr[15:0];
    r.data_res       = d;
    r.run_start      = run;
    r.last           = lst;
    return r;
  endfunction

  // apb register port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {25'd0, device_base} : 32'd0;

  assign req_stall = (state != ST_IDLE);
  assign out_free  = !res_valid || !res_stall;

  assign in_tag     = r_req.addr[ADDR_W-1:OFF_W];
  assign in_off     = r_req.addr[OFF_W-1:0];
  assign tag_hit    = (in_tag == page_tag);
  assign valid_eff  = page_valid && !retag;
  assign need_flush = ((r_req.op == OP_WRITE) && !tag_hit) ||
                      ((r_req.op == OP_READ) && (page_modified || !tag_hit)) ||
                      (r_req.op == OP_FLUSH);

  // the scan walks idx, otherwise the pointer set by the act step
  assign rd_addr = ((state == ST_FLUSH) || (state == ST_FL_OUT)) ? idx : rd_ptr;

  always_comb begin
    dirty_rest      = dirty;
    dirty_rest[idx] = 1'b0;
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = in_off;
    mem_wd = r_req.data;
    if ((state == ST_ACT) && out_free) begin
      if (r_req.op == OP_WRITE) begin
        mem_we = 1'b1;
      end else if ((r_req.op == OP_FILL) && fill_pending) begin
        mem_we = 1'b1;
        mem_wa = fill_pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      page_mem[mem_wa] <= mem_wd;
    end
    rdata <= page_mem[rd_addr];
  end

  always_comb begin
    res_load = 1'b0;
    res_next = make_res(KIND_READ, {page_tag, rd_ptr}, rdata, 1'b0, 1'b1, device_base);
    unique case (state)
      ST_FL_OUT: begin
        res_load = out_free;
        // last dirty byte ends the item unless a read still follows
        res_next = make_res(KIND_DIRTY, {page_tag, idx}, rdata, !prev,
                            (dirty_rest == '0) && (r_req.op != OP_READ), device_base);
      end
      ST_ACT: begin
        if ((r_req.op == OP_READ) && !valid_eff) begin
          res_load = out_free;
          res_next = make_res(KIND_FILL_REQ, {in_tag, {OFF_W{1'b0}}}, 8'd0, 1'b0, 1'b1,
                              device_base);
        end else if ((r_req.op == OP_FAIL) && fill_pending) begin
          res_load = out_free;
          res_next = make_res(KIND_ERROR, {page_tag, req_offset}, 8'd0, 1'b0, 1'b1,
                              device_base);
        end
      end
      ST_RD_OUT: begin
        res_load = out_free;
      end
      default: begin
        res_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res <= res_next;
    end
    if (req_valid && !req_stall) begin
      r_req <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      res_valid     <= 1'b0;
      device_base   <= DEVICE_BASE_RESET;
      dirty         <= '0;
      page_tag      <= '0;
      page_valid    <= 1'b0;
      page_modified <= 1'b0;
      fill_pending  <= 1'b0;
      fill_pos      <= '0;
      req_offset    <= '0;
      idx           <= '0;
      prev          <= 1'b0;
      retag         <= 1'b0;
      rd_ptr        <= '0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      if (cfg_we) begin
        device_base <= pwdata[DEV_W-1:0];
      end
      unique case (state)
        ST_IDLE: begin
          if (req_valid) begin
            state <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          // write, read and flush abandon a pending fill
          if ((r_req.op == OP_WRITE) || (r_req.op == OP_READ) || (r_req.op == OP_FLUSH)) begin
            fill_pending <= 1'b0;
          end
          retag <= need_flush;
          idx   <= '0;
          prev  <= 1'b0;
          if (need_flush && page_modified) begin
            state <= ST_FLUSH;
          end else begin
            state <= ST_ACT;
          end
        end
        ST_FLUSH: begin
          if (dirty == '0) begin
            page_modified <= 1'b0;
            state         <= ST_ACT;
          end else if (dirty[idx]) begin
            state <= ST_FL_OUT;
          end else begin
            prev <= 1'b0;
            idx  <= idx + 1'b1;
          end
        end
        ST_FL_OUT: begin
          if (out_free) begin
            dirty[idx] <= 1'b0;
            prev       <= 1'b1;
            idx        <= idx + 1'b1;
            state      <= ST_FLUSH;
          end
        end
        ST_ACT: begin
          if (out_free) begin
            state <= ST_IDLE;
            unique case (r_req.op)
              OP_WRITE: begin
                page_tag      <= in_tag;
                dirty[in_off] <= 1'b1;
                page_valid    <= 1'b0;
                page_modified <= 1'b1;
              end
              OP_READ: begin
                if (retag) begin
                  page_tag   <= in_tag;
                  page_valid <= 1'b0;
                end
                if (!valid_eff) begin
                  fill_pending <= 1'b1;
                  fill_pos     <= '0;
                  req_offset   <= in_off;
                end else begin
                  rd_ptr <= in_off;
                  state  <= ST_RD_ISSUE;
                end
              end
              OP_FILL: begin
                if (fill_pending) begin
                  if (fill_pos == LAST_OFF) begin
                    fill_pending <= 1'b0;
                    fill_pos     <= '0;
                    page_valid   <= 1'b1;
                    rd_ptr       <= req_offset;
                    state        <= ST_RD_ISSUE;
                  end else begin
                    fill_pos <= fill_pos + 1'b1;
                  end
                end
              end
              OP_FAIL: begin
                if (fill_pending) begin
                  fill_pending <= 1'b0;
                  fill_pos     <= '0;
                  page_valid   <= 1'b0;
                end
              end
              default: begin
                page_valid <= page_valid;
              end
            endcase
          end
        end
        ST_RD_ISSUE: begin
          state <= ST_RD_OUT;
        end
        ST_RD_OUT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // a page with a fill outstanding is never valid
  a_fill_not_valid: assert property (@(posedge clk) disable iff (rst)
    fill_pending |-> !page_valid)
    else $error("fill pending on a valid page");

  // between requests the modified mark tracks the dirty flags
  a_modified_dirty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (page_modified == (|dirty)))
    else $error("modified mark out of step with dirty flags");

  // the scan only emits bytes that are dirty
  a_emit_dirty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FL_OUT) |-> dirty[idx])
    else $error("flush emitting a clean byte");

  // a fill request result leaves a fill outstanding
  a_fill_req: assert property (@(posedge clk) disable iff (rst)
    (res_load && (res_next.kind == KIND_FILL_REQ)) |=> fill_pending)
    else $error("fill request without pending fill");

endmodule

`default_nettype wire

>>> sim/eeprom_page_write_back_cache_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the eeprom page write-back cache with its own cache predictor
module eeprom_page_write_back_cache_tb;
  import epwbc_pkg::*;

  localparam int unsigned PAGE = 32;
  localparam int unsigned OFF_W = 5;
  localparam int unsigned TAG_W = ADDR_W - OFF_W;
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned PHASE_ITEMS = 20;
  localparam logic [2:0] REG_DEVICE_BASE = 3'd0;
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST = 3'd7;

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  req_t        req;
  logic        res_valid;
  logic        res_stall;
  res_t        res;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  eeprom_page_write_back_cache #(.PAGE_BYTES(PAGE)) i_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predicted cache contents
  logic [7:0]       line_data [PAGE];
  logic             line_dirty [PAGE];
  logic [TAG_W-1:0] line_tag;
  logic             line_valid;
  logic             line_modified;
  logic             fill_busy;
  int unsigned      fill_pos;
  logic [OFF_W-1:0] want_off;
  logic [DEV_W-1:0] dev_base;

  res_t cache_results_q[$];
  res_t step_results[$];

  int unsigned errors;
  int unsigned sent_items;
  int unsigned idle_cycles;
  bit          steady;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void reset_cache_model();
    foreach (line_data[i]) begin
      line_data[i] = 8'h00;
      line_dirty[i] = 1'b0;
    end
    line_tag = '0;
    line_valid = 1'b0;
    line_modified = 1'b0;
    fill_busy = 1'b0;
    fill_pos = 0;
    want_off = '0;
    dev_base = DEVICE_BASE_RESET;
  endfunction

  function automatic void push_result(logic [1:0] kind, logic [ADDR_W-1:0] byte_addr,
                                      logic [7:0] value, logic run);
    res_t r;
    r.kind = kind;
    // bank bits added to the base, wrapping at 7 bits
    r.device_address = dev_base + DEV_W'(byte_addr[ADDR_W-1:16]);
    r.word_address = byte_addr[15:0];
    r.data_res = value;
    r.run_start = run;
    r.last = 1'b0;
    step_results.push_back(r);
  endfunction

  function automatic void write_back_page();
    logic prev;
    prev = 1'b0;
    if (!line_modified) return;
    for (int i = 0; i < PAGE; i++) begin
      if (line_dirty[i]) begin
        push_result(KIND_DIRTY, {line_tag, OFF_W'(i)}, line_data[i], !prev);
        line_dirty[i] = 1'b0;
        prev = 1'b1;
      end else begin
        prev = 1'b0;
      end
    end
    line_modified = 1'b0;
  endfunction

  function automatic void cache_step(req_t r);
    logic [TAG_W-1:0] tag;
    logic [OFF_W-1:0] off;
    res_t tail;
    tag = r.addr[ADDR_W-1:OFF_W];
    off = r.addr[OFF_W-1:0];
    step_results.delete();
    // a write, read or flush drops a pending fill
    if (r.op == OP_WRITE || r.op == OP_READ || r.op == OP_FLUSH) fill_busy = 1'b0;
    case (r.op)
      OP_WRITE: begin
        if (tag != line_tag) begin
          write_back_page();
          line_tag = tag;
        end
        line_data[off] = r.data;
        line_dirty[off] = 1'b1;
        line_valid = 1'b0;
        line_modified = 1'b1;
      end
      OP_READ: begin
        if (line_modified || tag != line_tag) begin
          write_back_page();
          line_tag = tag;
          line_valid = 1'b0;
        end
        if (!line_valid) begin
          push_result(KIND_FILL_REQ, {line_tag, OFF_W'(0)}, 8'h00, 1'b0);
          fill_busy = 1'b1;
          fill_pos = 0;
          want_off = off;
        end else begin
          push_result(KIND_READ, r.addr, line_data[off], 1'b0);
        end
      end
      OP_FLUSH: write_back_page();
      OP_FILL: begin
        if (fill_busy) begin
          line_data[fill_pos] = r.data;
          if (fill_pos == PAGE - 1) begin
            fill_busy = 1'b0;
            fill_pos = 0;
            line_valid = 1'b1;
            push_result(KIND_READ, {line_tag, want_off}, line_data[want_off], 1'b0);
          end else begin
            fill_pos++;
          end
        end
      end
      OP_FAIL: begin
        if (fill_busy) begin
          fill_busy = 1'b0;
          fill_pos = 0;
          line_valid = 1'b0;
          foreach (line_data[i]) line_data[i] = 8'hFF;
          push_result(KIND_ERROR, {line_tag, want_off}, 8'h00, 1'b0);
        end
      end
      default: ;
    endcase
    if (step_results.size() > 0) begin
      tail = step_results.pop_back();
      tail.last = 1'b1;
      step_results.push_back(tail);
    end
    foreach (step_results[i]) cache_results_q.push_back(step_results[i]);
  endfunction

  // called and returns at a falling edge
  task automatic send_request(logic [2:0] code, logic [ADDR_W-1:0] byte_addr,
                              logic [7:0] value);
    int gap;
    req_t item;
    gap = steady ? 0 : pick_gap();
    item.op = code;
    item.addr = byte_addr;
    item.data = value;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    if (code <= OP_FLUSH || ((code == OP_FILL || code == OP_FAIL) && fill_busy))
      sent_items++;
    cache_step(item);
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    req_valid <= 1'b0;
    while (cache_results_q.size() != 0) @(posedge clk);
    // no-result requests may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_device_base(logic [DEV_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_DEVICE_BASE;
    pwdata <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    dev_base = value;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[DEV_W-1:0] !== value)
      report_mismatch($sformatf("device_base read 0x%0h want 0x%0h", prdata, value));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_fill_and_hit();
    logic [7:0] value;
    // bank 7, top page, miss from reset
    send_request(OP_READ, 19'h7FFE3, 8'h00);
    for (int i = 0; i < PAGE; i++) begin
      value = (i == 0) ? 8'h00 : (i == PAGE - 1) ? 8'hFF : 8'($urandom);
      send_request(OP_FILL, ADDR_W'($urandom), value);
    end
    send_request(OP_READ, 19'h7FFFF, 8'hFF);
    send_request(OP_READ, 19'h7FFE0, 8'h00);
    // stray fill traffic and spare opcodes are ignored
    send_request(OP_FILL, 19'h00000, 8'hFF);
    send_request(OP_FAIL, 19'h7FFFF, 8'h00);
    for (int op = int'(OP_SPARE_FIRST); op <= int'(OP_SPARE_LAST); op++)
      send_request(3'(op), ADDR_W'($urandom), 8'($urandom));
  endtask

  task automatic test_write_flush();
    logic [OFF_W-1:0] offs [6] = '{5'd0, 5'd1, 5'd2, 5'd5, 5'd6, 5'd31};
    foreach (offs[i])
      send_request(OP_WRITE, {TAG_W'(1), offs[i]},
                   (i == 0) ? 8'hFF : (i == 1) ? 8'h00 : 8'($urandom));
    send_request(OP_FLUSH, 19'h00000, 8'h00);
    // second flush finds the page clean
    send_request(OP_FLUSH, 19'h7FFFF, 8'hFF);
    send_request(OP_WRITE, {TAG_W'(1), 5'd4}, 8'hA5);
    // write to another page pushes out the old one first
    send_request(OP_WRITE, {TAG_W'(2), 5'd0}, 8'h5A);
    send_request(OP_FLUSH, 19'h00000, 8'h00);
  endtask

  task automatic test_read_modified();
    send_request(OP_WRITE, 19'h000A7, 8'h3C);
    send_request(OP_READ, 19'h000A7, 8'h00);
    repeat (3) send_request(OP_FILL, ADDR_W'($urandom), 8'($urandom));
    send_request(OP_FAIL, 19'h00000, 8'h00);
    send_request(OP_READ, 19'h000B0, 8'h00);
    repeat (2) send_request(OP_FILL, ADDR_W'($urandom), 8'($urandom));
    // a read and then a write abandon the pending fill
    send_request(OP_READ, 19'h000A1, 8'h00);
    send_request(OP_WRITE, 19'h000A2, 8'h77);
    send_request(OP_FILL, 19'h000A0, 8'h11);
    send_request(OP_FLUSH, 19'h00000, 8'h00);
  endtask

  task automatic test_device_base();
    wait_for_results();
    write_device_base(7'h7F);
    // base plus bank wraps past 127
    send_request(OP_READ, {3'h7, 16'($urandom)}, 8'h00);
    send_request(OP_FAIL, ADDR_W'($urandom), 8'h00);
    send_request(OP_WRITE, {3'h1, 16'($urandom)}, 8'($urandom));
    send_request(OP_FLUSH, 19'h00000, 8'h00);
    wait_for_results();
    write_device_base(7'h00);
    send_request(OP_READ, {3'h0, 16'($urandom)}, 8'h00);
    send_request(OP_FAIL, ADDR_W'($urandom), 8'h00);
    send_request(OP_READ, {3'h7, 16'($urandom)}, 8'h00);
    send_request(OP_FAIL, ADDR_W'($urandom), 8'h00);
  endtask

  task automatic test_random_traffic();
    logic [TAG_W-1:0]  tags [3];
    logic [ADDR_W-1:0] addr;
    logic [OFF_W-1:0]  off;
    int unsigned       start;
    int                choice;
    int                count;
    int                cut;
    int                outcome;
    bit                in_order;
    for (int phase = 0; phase < 3; phase++) begin
      // idle between phases, so every expected result is in first
      wait_for_results();
      if (phase == 1) write_device_base(DEVICE_BASE_RESET);
      else write_device_base(DEV_W'($urandom));
      steady = (phase == 1);
      foreach (tags[i]) tags[i] = TAG_W'($urandom);
      start = sent_items;
      while (sent_items - start < PHASE_ITEMS) begin
        choice = $urandom_range(0, 99);
        if (choice < 35) begin
          addr = ($urandom_range(0, 9) == 0) ? ADDR_W'($urandom)
                                             : {tags[$urandom_range(0, 2)], OFF_W'($urandom)};
          count = $urandom_range(1, 6);
          in_order = 1'($urandom_range(0, 1));
          off = addr[OFF_W-1:0];
          for (int k = 0; k < count; k++) begin
            send_request(OP_WRITE, {addr[ADDR_W-1:OFF_W], off}, 8'($urandom));
            off = in_order ? off + 1'b1 : OFF_W'($urandom);
          end
        end else if (choice < 55) begin
          addr = {tags[$urandom_range(0, 2)], OFF_W'($urandom)};
          send_request(OP_READ, addr, 8'($urandom));
          outcome = $urandom_range(0, 9);
          cut = (outcome < 2) ? $urandom_range(0, PAGE - 1) : PAGE;
          for (int k = 0; k < cut; k++)
            send_request(OP_FILL, ADDR_W'($urandom), 8'($urandom));
          if (outcome == 0) begin
            send_request(OP_FAIL, ADDR_W'($urandom), 8'($urandom));
          end else if (outcome == 1) begin
            send_request(3'($urandom_range(OP_WRITE, OP_FLUSH)),
                         {addr[ADDR_W-1:OFF_W], OFF_W'($urandom)}, 8'($urandom));
          end else begin
            // hits on the freshly filled page
            repeat ($urandom_range(0, 3))
              send_request(OP_READ, {addr[ADDR_W-1:OFF_W], OFF_W'($urandom)},
                           8'($urandom));
          end
        end else if (choice < 70) begin
          send_request(OP_FLUSH, ADDR_W'($urandom), 8'($urandom));
        end else if (choice < 85) begin
          send_request(OP_READ, {tags[$urandom_range(0, 2)], OFF_W'($urandom)},
                       8'($urandom));
        end else begin
          send_request(3'($urandom_range(OP_FILL, OP_SPARE_LAST)), ADDR_W'($urandom),
                       8'($urandom));
        end
      end
    end
    steady = 1'b0;
  endtask

  // result side: random stall pattern
  initial begin
    int stall_left;
    stall_left = 0;
    res_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (steady) begin
        res_stall <= 1'b0;
      end else if (stall_left > 0) begin
        res_stall <= 1'b1;
        stall_left--;
      end else begin
        res_stall <= 1'b0;
        stall_left = pick_gap();
      end
    end
  end

  // compare each accepted result with the oldest prediction
  initial begin
    res_t want;
    forever begin
      @(posedge clk);
      if (!rst && res_valid && !res_stall) begin
        if (cache_results_q.size() == 0) begin
          report_mismatch($sformatf("result 0x%0h with nothing expected", res));
        end else begin
          want = cache_results_q.pop_front();
          check_field("kind", 16'(res.kind), 16'(want.kind));
          check_field("device_address", 16'(res.device_address), 16'(want.device_address));
          check_field("word_address", res.word_address, want.word_address);
          check_field("data_res", 16'(res.data_res), 16'(want.data_res));
          check_field("run_start", 16'(res.run_start), 16'(want.run_start));
          check_field("last", 16'(res.last), 16'(want.last));
        end
      end
    end
  end

  // cycles with no request or result moving
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (req_valid && !req_stall) || (res_valid && !res_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    sent_items = 0;
    steady = 1'b0;
    reset_cache_model();
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_fill_and_hit();
    test_write_flush();
    test_read_modified();
    test_device_base();
    test_random_traffic();
    wait_for_results();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> files.f
src/epwbc_pkg.sv
src/eeprom_page_write_back_cache.sv
sim/eeprom_page_write_back_cache_tb.sv
